// ===== hw/rtl/stcd_pkg.sv =====
// Shared constants, types and font helpers for the scrolling text column driver.
`timescale 1ns / 1ps

package stcd_pkg;

  localparam int MSG_DEPTH   = 256;
  localparam int ADDR_W      = $clog2(MSG_DEPTH);
  localparam int CHAR_W      = 8;
  localparam int POS_W       = CHAR_W + 1;
  localparam int COL_W       = 6;
  localparam int OFS_W       = 3;
  localparam int SLOT_W      = 3;
  localparam int ROW_BITS    = 7;
  localparam int WINDOW_COLS = 40;
  localparam int GLYPH_COLS  = 6;
  localparam int FONT_COLS   = 5;
  localparam int BLANK_GLYPH = 62;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MSG_LENGTH      = 1'd0,
    REG_FRAMES_PER_STEP = 1'd1
  } cfg_reg_t;

  typedef logic [ROW_BITS-1:0] font_col_t;
  typedef font_col_t           glyph_cols_t [FONT_COLS];

  // 5x7 glyphs: digits, upper case letters, lower case letters, then a blank.
  localparam glyph_cols_t FONT [BLANK_GLYPH + 1] = '{
    '{7'd62, 7'd69, 7'd73, 7'd81, 7'd62},   '{7'd17, 7'd33, 7'd127, 7'd1, 7'd1},
    '{7'd33, 7'd67, 7'd69, 7'd73, 7'd49},   '{7'd34, 7'd65, 7'd73, 7'd73, 7'd54},
    '{7'd12, 7'd20, 7'd36, 7'd127, 7'd4},   '{7'd114, 7'd81, 7'd81, 7'd81, 7'd78},
    '{7'd62, 7'd73, 7'd73, 7'd73, 7'd38},   '{7'd64, 7'd71, 7'd72, 7'd80, 7'd96},
    '{7'd54, 7'd73, 7'd73, 7'd73, 7'd54},   '{7'd50, 7'd73, 7'd73, 7'd73, 7'd62},
    '{7'd31, 7'd36, 7'd68, 7'd68, 7'd127},  '{7'd127, 7'd73, 7'd73, 7'd73, 7'd54},
    '{7'd62, 7'd65, 7'd65, 7'd65, 7'd34},   '{7'd127, 7'd65, 7'd65, 7'd65, 7'd62},
    '{7'd127, 7'd73, 7'd73, 7'd73, 7'd65},  '{7'd127, 7'd72, 7'd72, 7'd72, 7'd64},
    '{7'd62, 7'd65, 7'd65, 7'd69, 7'd38},   '{7'd127, 7'd8, 7'd8, 7'd8, 7'd127},
    '{7'd0, 7'd65, 7'd127, 7'd65, 7'd0},    '{7'd0, 7'd2, 7'd65, 7'd65, 7'd126},
    '{7'd127, 7'd8, 7'd20, 7'd34, 7'd65},   '{7'd127, 7'd1, 7'd1, 7'd1, 7'd1},
    '{7'd127, 7'd32, 7'd24, 7'd32, 7'd127}, '{7'd127, 7'd16, 7'd8, 7'd4, 7'd127},
    '{7'd62, 7'd65, 7'd65, 7'd65, 7'd62},   '{7'd127, 7'd72, 7'd72, 7'd72, 7'd48},
    '{7'd60, 7'd66, 7'd66, 7'd66, 7'd61},   '{7'd127, 7'd72, 7'd76, 7'd74, 7'd49},
    '{7'd50, 7'd73, 7'd73, 7'd73, 7'd38},   '{7'd64, 7'd64, 7'd127, 7'd64, 7'd64},
    '{7'd126, 7'd1, 7'd1, 7'd1, 7'd126},    '{7'd124, 7'd2, 7'd1, 7'd2, 7'd124},
    '{7'd126, 7'd1, 7'd6, 7'd1, 7'd126},    '{7'd99, 7'd20, 7'd8, 7'd20, 7'd99},
    '{7'd114, 7'd9, 7'd9, 7'd9, 7'd126},    '{7'd67, 7'd69, 7'd73, 7'd81, 7'd97},
    '{7'd6, 7'd21, 7'd21, 7'd21, 7'd15},    '{7'd63, 7'd9, 7'd9, 7'd9, 7'd6},
    '{7'd14, 7'd17, 7'd17, 7'd17, 7'd9},    '{7'd6, 7'd9, 7'd9, 7'd9, 7'd63},
    '{7'd14, 7'd21, 7'd21, 7'd21, 7'd13},   '{7'd8, 7'd31, 7'd40, 7'd40, 7'd0},
    '{7'd25, 7'd37, 7'd37, 7'd37, 7'd62},   '{7'd63, 7'd8, 7'd8, 7'd8, 7'd7},
    '{7'd0, 7'd9, 7'd47, 7'd1, 7'd0},       '{7'd2, 7'd1, 7'd1, 7'd1, 7'd94},
    '{7'd63, 7'd4, 7'd10, 7'd17, 7'd0},     '{7'd62, 7'd1, 7'd1, 7'd1, 7'd0},
    '{7'd31, 7'd16, 7'd15, 7'd16, 7'd31},   '{7'd31, 7'd16, 7'd16, 7'd15, 7'd0},
    '{7'd14, 7'd17, 7'd17, 7'd17, 7'd14},   '{7'd63, 7'd36, 7'd36, 7'd36, 7'd24},
    '{7'd24, 7'd36, 7'd36, 7'd36, 7'd63},   '{7'd0, 7'd15, 7'd16, 7'd16, 7'd0},
    '{7'd9, 7'd21, 7'd21, 7'd21, 7'd18},    '{7'd16, 7'd16, 7'd62, 7'd17, 7'd17},
    '{7'd30, 7'd1, 7'd1, 7'd2, 7'd31},      '{7'd0, 7'd30, 7'd1, 7'd1, 7'd30},
    '{7'd30, 7'd1, 7'd14, 7'd1, 7'd30},     '{7'd17, 7'd10, 7'd4, 7'd10, 7'd17},
    '{7'd57, 7'd5, 7'd5, 7'd5, 7'd62},      '{7'd17, 7'd19, 7'd21, 7'd25, 7'd17},
    '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0}
  };

  // Character code to glyph number; codes below '0' and codes mapped past the table land on the blank glyph.
  function automatic logic [5:0] glyph_of(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] g;
    g = CHAR_W'(BLANK_GLYPH);
    if (code == 8'd0 || code == 8'd32) begin
      g = CHAR_W'(BLANK_GLYPH);
    end else if (code >= 8'd97) begin
      g = code - 8'd61;
    end else if (code >= 8'd65) begin
      g = code - 8'd55;
    end else if (code >= 8'd48) begin
      g = code - 8'd48;
    end
    if (g > CHAR_W'(BLANK_GLYPH)) begin
      g = CHAR_W'(BLANK_GLYPH);
    end
    return g[5:0];
  endfunction

  // One font column of a glyph; the spacer column reads as zero.
  function automatic font_col_t font_column(input logic [5:0] g, input logic [OFS_W-1:0] gc);
    font_col_t col;
    col = '0;
    if (gc < OFS_W'(FONT_COLS) && g <= 6'(BLANK_GLYPH)) begin
      col = FONT[g][gc];
    end
    return col;
  endfunction

endpackage

// ===== hw/rtl/scrolling_text_column_driver.sv =====
// Top level of the scrolling text column driver for a 40-column LED matrix.
//
//   channel  direction  handshake            payload
//   in       request in in_valid / in_stall  op, char_index, char_code
//   out      result out out_valid / out_stall column_bits, frame_start, finished, idle
//   cfg      write only cfg_we               cfg_index, cfg_data
//
// A new request can be taken in every cycle unless in_stall holds it off. A tick is
// accepted into the lookup stage together with its registered message store read, and
// the font lookup loads the output register when it is empty or its result is taken.
// Reset clears the scroll state and the registers; the message store is not cleared.
// A result waiting in the output register does not block intake; the block stalls
// requests only when the lookup stage is full and the output register holds a
// stalled result.
`timescale 1ns / 1ps

module scrolling_text_column_driver (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            op,
  input  logic [stcd_pkg::CHAR_W-1:0]           char_index,
  input  logic [stcd_pkg::CHAR_W-1:0]           char_code,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [stcd_pkg::ROW_BITS-1:0]         column_bits,
  output logic                                  frame_start,
  output logic                                  finished,
  output logic                                  idle,
  input  logic                                  cfg_we,
  input  logic [stcd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stcd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import stcd_pkg::*;

  // Lookup stage: what a tick carries while its store read is in flight.
  typedef struct packed {
    logic             idle;
    logic             blank;
    logic [OFS_W-1:0] gc;
    logic             first;
    logic             done;
  } look_t;

  // Configuration registers.
  logic [CHAR_W-1:0] msg_length;
  logic [CHAR_W-1:0] frames_per_step;

  // Scroll state.
  logic              running;
  logic [COL_W-1:0]  column_position;
  logic [CHAR_W-1:0] frame_count;
  logic [OFS_W-1:0]  scroll_offset;
  logic [CHAR_W-1:0] chars_shifted;

  logic              running_next;
  logic [COL_W-1:0]  column_position_next;
  logic [CHAR_W-1:0] frame_count_next;
  logic [OFS_W-1:0]  scroll_offset_next;
  logic [CHAR_W-1:0] chars_shifted_next;
  logic              done_now;

  // Pipeline registers.
  logic  look_valid;
  look_t look;
  look_t look_next;

  logic in_accept;
  logic tick_accept;
  logic look_move;
  logic out_accept;

  // Window address arithmetic.
  logic [COL_W-1:0]    buf_col;
  logic [COL_W+5:0]    slot_prod;
  logic [SLOT_W-1:0]   slot;
  logic [COL_W-1:0]    slot_base;
  logic [COL_W-1:0]    gc_full;
  logic [POS_W-1:0]    pos;
  logic                pos_blank;

  logic [CHAR_W-1:0]   fps_eff;
  logic [CHAR_W-1:0]   frame_inc;
  logic [CHAR_W-1:0]   shifted_inc;

  logic                store_we;
  logic [CHAR_W-1:0]   store_rdata;
  logic [ROW_BITS-1:0] bits_now;

  assign in_accept   = in_valid && !in_stall;
  assign tick_accept = in_accept && (op == OP_TICK);
  assign out_accept  = out_valid && !out_stall;
  assign look_move   = look_valid && (!out_valid || !out_stall);
  assign in_stall    = look_valid && out_valid && out_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_length      <= '0;
      frames_per_step <= CHAR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MSG_LENGTH:      msg_length      <= cfg_data;
        REG_FRAMES_PER_STEP: frames_per_step <= cfg_data;
        default:             ;
      endcase
    end
  end

  // Buffer column b = offset + window column; glyph slot b/6 via the 43/256
  // reciprocal, which is exact for every column the window can reach.
  always_comb begin
    buf_col   = column_position + COL_W'(scroll_offset);
    slot_prod = (COL_W+6)'(buf_col) * (COL_W+6)'(43);
    slot      = slot_prod[10:8];
    slot_base = COL_W'(slot) * COL_W'(GLYPH_COLS);
    gc_full   = buf_col - slot_base;
    pos       = POS_W'(chars_shifted) + POS_W'(slot);
    pos_blank = (gc_full >= COL_W'(FONT_COLS)) || (pos >= POS_W'(msg_length))
             || (pos >= POS_W'(MSG_DEPTH));
  end

  // Scroll advance for a tick taken while running.
  always_comb begin
    fps_eff              = (frames_per_step == '0) ? CHAR_W'(1) : frames_per_step;
    frame_inc            = frame_count + CHAR_W'(1);
    shifted_inc          = chars_shifted + CHAR_W'(1);
    running_next         = running;
    column_position_next = column_position + COL_W'(1);
    frame_count_next     = frame_count;
    scroll_offset_next   = scroll_offset;
    chars_shifted_next   = chars_shifted;
    done_now             = 1'b0;
    if (column_position == COL_W'(WINDOW_COLS - 1)) begin
      column_position_next = '0;
      frame_count_next     = frame_inc;
      if (frame_inc >= fps_eff) begin
        // A full group of frames has gone by: move the window one column.
        frame_count_next = '0;
        if (scroll_offset == OFS_W'(GLYPH_COLS - 1)) begin
          scroll_offset_next = '0;
          chars_shifted_next = shifted_inc;
        end else begin
          scroll_offset_next = scroll_offset + OFS_W'(1);
        end
        // The scroll ends once the last character is fully inside the window.
        if (POS_W'(chars_shifted_next) + POS_W'(8) > POS_W'(msg_length)) begin
          running_next = 1'b0;
          done_now     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      column_position <= '0;
      frame_count     <= '0;
      scroll_offset   <= '0;
      chars_shifted   <= '0;
    end else if (in_accept && op == OP_START) begin
      // A start restarts the scroll from the first character.
      running         <= 1'b1;
      column_position <= '0;
      frame_count     <= '0;
      scroll_offset   <= '0;
      chars_shifted   <= '0;
    end else if (tick_accept && running) begin
      running         <= running_next;
      column_position <= column_position_next;
      frame_count     <= frame_count_next;
      scroll_offset   <= scroll_offset_next;
      chars_shifted   <= chars_shifted_next;
    end
  end

  // Message store: a write lands at its accept edge, so a tick taken on the
  // next cycle already reads the new character.
  assign store_we = in_accept && (op == OP_WRITE)
                 && ((CHAR_W+1)'(char_index) < (CHAR_W+1)'(MSG_DEPTH));

  stcd_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MSG_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (char_index[ADDR_W-1:0]),
    .wdata (char_code),
    .re    (tick_accept),
    .raddr (pos[ADDR_W-1:0]),
    .rdata (store_rdata)
  );

  always_comb begin
    look_next.idle  = !running;
    look_next.blank = pos_blank;
    look_next.gc    = gc_full[OFS_W-1:0];
    look_next.first = (column_position == '0);
    look_next.done  = done_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      look_valid <= 1'b0;
    end else if (tick_accept) begin
      look_valid <= 1'b1;
    end else if (look_move) begin
      look_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      look <= look_next;
    end
  end

  // Font lookup on the store data; idle ticks and blank positions give zero.
  assign bits_now = (look.idle || look.blank) ? '0
                  : font_column(glyph_of(store_rdata), look.gc);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (look_move) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_move) begin
      column_bits <= bits_now;
      frame_start <= !look.idle && look.first;
      finished    <= !look.idle && look.done;
      idle        <= look.idle;
    end
  end

endmodule

// ===== hw/rtl/stcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module stcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/stcd_checker.sv =====
// Port-level checks for the scrolling text column driver, bound to the top level.
`timescale 1ns / 1ps

module stcd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [stcd_pkg::ROW_BITS-1:0]   column_bits,
  input logic                            frame_start,
  input logic                            finished,
  input logic                            idle
);

  import stcd_pkg::*;

  // A held result keeps its payload until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(column_bits) && $stable(finished)
      && $stable(frame_start) && $stable(idle))
    else $error("result changed while stalled");

  // An idle tick reports nothing but the idle flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> column_bits == '0 && !frame_start && !finished)
    else $error("idle result carries column data");

  // The end of a scroll is flagged only by a running tick.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> !idle)
    else $error("finished flagged on an idle tick");

  // No result survives a reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind scrolling_text_column_driver stcd_checker u_stcd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .column_bits (column_bits),
  .frame_start (frame_start),
  .finished    (finished),
  .idle        (idle)
);

// ===== tb/scrolling_text_column_driver_test.sv =====
// Self-checking testbench for the scrolling text column driver: directed and random requests.
`timescale 1ns / 1ps

module scrolling_text_column_driver_test;
  import stcd_pkg::*;

  // Geometry of the display as the predictor sees it.
  localparam int SCREEN_COLS     = 40;
  localparam int GLYPH_WIDTH     = 6;
  localparam int FONT_WIDTH      = 5;
  localparam int STOP_SLOTS      = 8;
  localparam int BLANK_GLYPH_NUM = 62;
  localparam int STORE_DEPTH     = 256;

  // Run shape.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 300;
  localparam int MAX_REPORTS   = 40;
  localparam int IDLE_MAX      = 15;
  localparam int HOLD_CYCLES   = 200;

  // The request code that the block must ignore.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Character sets for the glyph mapping checks, first character in the top byte.
  // Set one: NUL, space, '0', '9', 'A', 'Z', 'a'.
  localparam logic [55:0] MAP_CODES_LOW  = {8'd0, 8'd32, 8'd48, 8'd57, 8'd65, 8'd90, 8'd97};
  // Set two: 'z', '{' (just past the letters), 255, '!', ':', '`', '/'.
  localparam logic [55:0] MAP_CODES_HIGH = {8'd122, 8'd123, 8'd255, 8'd33, 8'd58, 8'd96, 8'd47};

  typedef struct packed {
    logic [6:0] bits;
    logic       first;
    logic       done;
    logic       idle;
  } column_t;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [1:0]            op          = OP_WRITE;
  logic [CHAR_W-1:0]     char_index  = '0;
  logic [CHAR_W-1:0]     char_code   = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [ROW_BITS-1:0]   column_bits;
  logic                  frame_start;
  logic                  finished;
  logic                  idle;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  // Sender gap and receiver stall ranges; zero gives a stretch with no idling.
  int tx_gap_max  = 0;
  int rx_wait_max = 0;
  // A long receiver hold-off, picked up by the receiver at its next result.
  int hold_cycles = 0;
  int error_count = 0;

  // Predicted columns, oldest first.
  column_t expected_columns[$];

  // Predictor copy of the message store, the registers and the scroll state.
  logic [7:0] msg_mem     [STORE_DEPTH];
  bit         msg_written [STORE_DEPTH];
  logic [7:0] len_reg   = 8'd0;
  logic [7:0] fps_reg   = 8'd1;
  bit         scrolling = 1'b0;
  int         col_pos   = 0;
  int         frame_cnt = 0;
  int         shift_ofs = 0;
  int         chars_out = 0;

  scrolling_text_column_driver u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .char_index  (char_index),
    .char_code   (char_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .column_bits (column_bits),
    .frame_start (frame_start),
    .finished    (finished),
    .idle        (idle),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Character code to glyph number. Digits, upper case and lower case each map
  // by a fixed offset; any code below '0', and anything mapped past the table, is blank.
  function automatic int glyph_number(logic [7:0] code);
    int g;
    if (code == 8'd0 || code == 8'd32) g = BLANK_GLYPH_NUM;
    else if (code >= 8'd97) g = code - 61;
    else if (code >= 8'd65) g = code - 55;
    else if (code >= 8'd48) g = code - 48;
    else g = BLANK_GLYPH_NUM;
    return (g > BLANK_GLYPH_NUM) ? BLANK_GLYPH_NUM : g;
  endfunction

  // The five font columns of a glyph, leftmost column in the top seven bits.
  function automatic logic [34:0] glyph_columns(int g);
    case (g)
      0:  return {7'd62, 7'd69, 7'd73, 7'd81, 7'd62};
      1:  return {7'd17, 7'd33, 7'd127, 7'd1, 7'd1};
      2:  return {7'd33, 7'd67, 7'd69, 7'd73, 7'd49};
      3:  return {7'd34, 7'd65, 7'd73, 7'd73, 7'd54};
      4:  return {7'd12, 7'd20, 7'd36, 7'd127, 7'd4};
      5:  return {7'd114, 7'd81, 7'd81, 7'd81, 7'd78};
      6:  return {7'd62, 7'd73, 7'd73, 7'd73, 7'd38};
      7:  return {7'd64, 7'd71, 7'd72, 7'd80, 7'd96};
      8:  return {7'd54, 7'd73, 7'd73, 7'd73, 7'd54};
      9:  return {7'd50, 7'd73, 7'd73, 7'd73, 7'd62};
      10: return {7'd31, 7'd36, 7'd68, 7'd68, 7'd127};
      11: return {7'd127, 7'd73, 7'd73, 7'd73, 7'd54};
      12: return {7'd62, 7'd65, 7'd65, 7'd65, 7'd34};
      13: return {7'd127, 7'd65, 7'd65, 7'd65, 7'd62};
      14: return {7'd127, 7'd73, 7'd73, 7'd73, 7'd65};
      15: return {7'd127, 7'd72, 7'd72, 7'd72, 7'd64};
      16: return {7'd62, 7'd65, 7'd65, 7'd69, 7'd38};
      17: return {7'd127, 7'd8, 7'd8, 7'd8, 7'd127};
      18: return {7'd0, 7'd65, 7'd127, 7'd65, 7'd0};
      19: return {7'd0, 7'd2, 7'd65, 7'd65, 7'd126};
      20: return {7'd127, 7'd8, 7'd20, 7'd34, 7'd65};
      21: return {7'd127, 7'd1, 7'd1, 7'd1, 7'd1};
      22: return {7'd127, 7'd32, 7'd24, 7'd32, 7'd127};
      23: return {7'd127, 7'd16, 7'd8, 7'd4, 7'd127};
      24: return {7'd62, 7'd65, 7'd65, 7'd65, 7'd62};
      25: return {7'd127, 7'd72, 7'd72, 7'd72, 7'd48};
      26: return {7'd60, 7'd66, 7'd66, 7'd66, 7'd61};
      27: return {7'd127, 7'd72, 7'd76, 7'd74, 7'd49};
      28: return {7'd50, 7'd73, 7'd73, 7'd73, 7'd38};
      29: return {7'd64, 7'd64, 7'd127, 7'd64, 7'd64};
      30: return {7'd126, 7'd1, 7'd1, 7'd1, 7'd126};
      31: return {7'd124, 7'd2, 7'd1, 7'd2, 7'd124};
      32: return {7'd126, 7'd1, 7'd6, 7'd1, 7'd126};
      33: return {7'd99, 7'd20, 7'd8, 7'd20, 7'd99};
      34: return {7'd114, 7'd9, 7'd9, 7'd9, 7'd126};
      35: return {7'd67, 7'd69, 7'd73, 7'd81, 7'd97};
      36: return {7'd6, 7'd21, 7'd21, 7'd21, 7'd15};
      37: return {7'd63, 7'd9, 7'd9, 7'd9, 7'd6};
      38: return {7'd14, 7'd17, 7'd17, 7'd17, 7'd9};
      39: return {7'd6, 7'd9, 7'd9, 7'd9, 7'd63};
      40: return {7'd14, 7'd21, 7'd21, 7'd21, 7'd13};
      41: return {7'd8, 7'd31, 7'd40, 7'd40, 7'd0};
      42: return {7'd25, 7'd37, 7'd37, 7'd37, 7'd62};
      43: return {7'd63, 7'd8, 7'd8, 7'd8, 7'd7};
      44: return {7'd0, 7'd9, 7'd47, 7'd1, 7'd0};
      45: return {7'd2, 7'd1, 7'd1, 7'd1, 7'd94};
      46: return {7'd63, 7'd4, 7'd10, 7'd17, 7'd0};
      47: return {7'd62, 7'd1, 7'd1, 7'd1, 7'd0};
      48: return {7'd31, 7'd16, 7'd15, 7'd16, 7'd31};
      49: return {7'd31, 7'd16, 7'd16, 7'd15, 7'd0};
      50: return {7'd14, 7'd17, 7'd17, 7'd17, 7'd14};
      51: return {7'd63, 7'd36, 7'd36, 7'd36, 7'd24};
      52: return {7'd24, 7'd36, 7'd36, 7'd36, 7'd63};
      53: return {7'd0, 7'd15, 7'd16, 7'd16, 7'd0};
      54: return {7'd9, 7'd21, 7'd21, 7'd21, 7'd18};
      55: return {7'd16, 7'd16, 7'd62, 7'd17, 7'd17};
      56: return {7'd30, 7'd1, 7'd1, 7'd2, 7'd31};
      57: return {7'd0, 7'd30, 7'd1, 7'd1, 7'd30};
      58: return {7'd30, 7'd1, 7'd14, 7'd1, 7'd30};
      59: return {7'd17, 7'd10, 7'd4, 7'd10, 7'd17};
      60: return {7'd57, 7'd5, 7'd5, 7'd5, 7'd62};
      61: return {7'd17, 7'd19, 7'd21, 7'd25, 7'd17};
      default: return 35'd0;
    endcase
  endfunction

  // Column b of the strip that starts at the first glyph still in view. The
  // sixth column of every glyph is the spacer, and positions at or past the
  // message length are blank.
  function automatic logic [6:0] window_column(int b);
    int          pos;
    int          gc;
    logic [34:0] cols;
    pos = chars_out + b / GLYPH_WIDTH;
    gc  = b % GLYPH_WIDTH;
    if (gc >= FONT_WIDTH || pos >= len_reg || pos >= STORE_DEPTH) return 7'd0;
    cols = glyph_columns(glyph_number(msg_mem[pos]));
    return cols[34 - 7 * gc -: 7];
  endfunction

  // Apply one accepted request to the predicted state; a tick queues its column.
  task automatic step_scroll_model(logic [1:0] code_op, logic [7:0] idx, logic [7:0] code);
    column_t c;
    int      fps;
    case (code_op)
      OP_WRITE: begin
        msg_mem[idx]     = code;
        msg_written[idx] = 1'b1;
      end
      OP_START: begin
        // A start also restarts a scroll that is already running.
        scrolling = 1'b1;
        col_pos   = 0;
        frame_cnt = 0;
        shift_ofs = 0;
        chars_out = 0;
      end
      OP_TICK: begin
        c = '0;
        if (!scrolling) begin
          c.idle = 1'b1;
        end else begin
          c.bits  = window_column(shift_ofs + col_pos);
          c.first = (col_pos == 0);
          col_pos++;
          if (col_pos >= SCREEN_COLS) begin
            col_pos = 0;
            // A step count of zero behaves like one.
            fps = (fps_reg == 8'd0) ? 1 : fps_reg;
            frame_cnt++;
            if (frame_cnt >= fps) begin
              frame_cnt = 0;
              shift_ofs++;
              if (shift_ofs >= GLYPH_WIDTH) begin
                shift_ofs = 0;
                chars_out++;
              end
              // The scroll ends once the last character is fully in view.
              if (STOP_SLOTS + chars_out > len_reg) begin
                scrolling = 1'b0;
                c.done    = 1'b1;
              end
            end
          end
        end
        expected_columns.push_back(c);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap and hold it until the block takes it.
  // The prediction is made at the edge where the request is accepted.
  task automatic send_request(logic [1:0] code_op, logic [7:0] idx, logic [7:0] code);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= code_op;
    char_index <= idx;
    char_code  <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_scroll_model(code_op, idx, code);
  endtask

  // A tick carries random bits in the fields it does not use.
  task automatic send_tick();
    send_request(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_start();
    send_request(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Mostly printable characters, with the occasional arbitrary code.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(48, 57));
      1:       return 8'($urandom_range(65, 90));
      2:       return 8'($urandom_range(97, 122));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // The store is not cleared by reset, so every position a scroll can read
  // gets written before the message length covers it.
  task automatic fill_message(int len);
    for (int i = 0; i < len; i++) begin
      if (!msg_written[i]) send_request(OP_WRITE, 8'(i), pick_char());
    end
  endtask

  // Drop valid, wait for every predicted column, then give requests that
  // produce no column time to drain out of the pipeline.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_columns.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(cfg_reg_t r, logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (r == REG_MSG_LENGTH) len_reg = v;
    else fps_reg = v;
  endtask

  // Registers change only with the block quiet.
  task automatic load_scroll_setup(logic [7:0] len, logic [7:0] fps);
    fill_message(len);
    settle();
    write_register(REG_MSG_LENGTH, len);
    write_register(REG_FRAMES_PER_STEP, fps);
  endtask

  task automatic run_to_end();
    while (scrolling) send_tick();
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // For each result the receiver stalls a random number of cycles, or for a
  // long hold-off when one has been asked for, then takes the result.
  initial begin : result_receiver
    int wait_cycles;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = (rx_wait_max > 0) ? $urandom_range(0, rx_wait_max) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      if (error_count < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Outputs are sampled at the rising edge and compared at the falling edge that
  // follows, so the comparison never races the predictor.
  initial begin : column_check
    column_t got;
    column_t want;
    bit      taken;
    forever begin
      @(posedge clk);
      taken = !rst && out_valid && !out_stall;
      got   = {column_bits, frame_start, finished, idle};
      @(negedge clk);
      if (taken) begin
        if (expected_columns.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("%0t ns: column with nothing expected, expected none, actual %h",
                     $time, got);
          error_count++;
        end else begin
          want = expected_columns.pop_front();
          compare_field("column_bits", want.bits, got.bits);
          compare_field("frame_start", want.first, got.first);
          compare_field("finished", want.done, got.done);
          compare_field("idle", want.idle, got.idle);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks with no scroll running come back blank with idle set, and the
  // unused request code is dropped without a result.
  task automatic test_idle_ticks();
    tx_gap_max  = 0;
    rx_wait_max = 0;
    send_tick();
    send_request(OP_RESERVED, 8'hFF, 8'hFF);
    send_tick();
    send_tick();
  endtask

  // A seven-character message fits one frame; the scroll ends after that frame
  // and the following ticks are idle again.
  task automatic show_characters(logic [55:0] codes);
    for (int i = 0; i < 7; i++) send_request(OP_WRITE, 8'(i), codes[8 * (6 - i) +: 8]);
    load_scroll_setup(8'd7, 8'd1);
    send_start();
    run_to_end();
    send_tick();
    send_tick();
  endtask

  task automatic test_character_map();
    tx_gap_max  = IDLE_MAX;
    rx_wait_max = IDLE_MAX;
    show_characters(MAP_CODES_LOW);
    show_characters(MAP_CODES_HIGH);
    // An empty message still shows one blank frame and then finishes.
    load_scroll_setup(8'd0, 8'd1);
    send_start();
    run_to_end();
  endtask

  // Each frame repeats before the window moves; a seven-character message
  // shows three identical frames and ends at the first move.
  task automatic test_frame_repeat();
    tx_gap_max  = IDLE_MAX;
    rx_wait_max = 0;
    load_scroll_setup(8'd7, 8'd3);
    send_start();
    run_to_end();
  endtask

  task automatic test_zero_step_count();
    tx_gap_max  = 0;
    rx_wait_max = IDLE_MAX;
    load_scroll_setup(8'd8, 8'd0);
    send_start();
    run_to_end();
  endtask

  // Writes land in the running scroll at once, and a start mid-scroll restarts it.
  task automatic test_restart_and_live_edit();
    tx_gap_max  = IDLE_MAX;
    rx_wait_max = IDLE_MAX;
    load_scroll_setup(8'd12, 8'd1);
    send_start();
    repeat (50) send_tick();
    send_request(OP_WRITE, 8'd2, pick_char());
    send_request(OP_WRITE, 8'd200, pick_char());
    repeat (30) send_tick();
    send_request(OP_RESERVED, 8'd0, 8'd0);
    send_start();
    repeat (45) send_tick();
  endtask

  // Largest length and step count: the window stays put over repeated frames.
  task automatic test_full_length_slow_scroll();
    tx_gap_max  = 0;
    rx_wait_max = 0;
    load_scroll_setup(8'd255, 8'd255);
    send_start();
    repeat (SCREEN_COLS * 2 + 10) send_tick();
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so the
  // block fills up and stalls its request side.
  task automatic test_output_backpressure();
    tx_gap_max  = 0;
    rx_wait_max = 3;
    load_scroll_setup(8'd9, 8'd1);
    send_start();
    hold_cycles = HOLD_CYCLES;
    repeat (100) send_tick();
  endtask

  // Random phases: a setup, a start, then mostly ticks with live writes,
  // restarts and ignored requests mixed in. Half the phases use short
  // messages so scrolls run to their end.
  task automatic test_random_traffic();
    int sent;
    int steps;
    int pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_gap_max  = $urandom_range(0, 1) ? IDLE_MAX : 0;
      rx_wait_max = $urandom_range(0, 1) ? IDLE_MAX : 0;
      if ($urandom_range(0, 1))
        load_scroll_setup(8'($urandom_range(0, 9)), 8'($urandom_range(0, 2)));
      else
        load_scroll_setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_start();
      sent++;
      steps = $urandom_range(40, 150);
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_tick();
          sent++;
        end else if (pick < 90) begin
          send_request(OP_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          sent++;
        end else if (pick < 95) begin
          send_start();
          sent++;
        end else begin
          send_request(OP_RESERVED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_ticks();
    test_character_map();
    test_frame_repeat();
    test_zero_step_count();
    test_restart_and_live_edit();
    test_full_length_slow_scroll();
    test_output_backpressure();
    test_random_traffic();
    settle();
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // A correct run takes well under a tenth of this.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
